// ===== design/rtd_pkg.sv =====
// Shared types and constants for the ring termination detector.
package rtd_pkg;

	localparam int MAX_NODES       = 64;
	localparam int COUNT_WIDTH     = 32;
	localparam int RANK_WIDTH      = 6;
	localparam int NCOUNT_WIDTH    = 7;
	localparam int SUM_WIDTH       = 32;
	localparam int CMD_WIDTH       = 3;
	localparam int ACTION_WIDTH    = 2;
	localparam int CFG_INDEX_WIDTH = 1;
	localparam int CFG_DATA_WIDTH  = 7;
	localparam int IN_DATA_WIDTH   = 64;
	localparam int OUT_DATA_WIDTH  = 72;

	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_DATA_SENT    = 3'd0,
		CMD_DATA_ARRIVED = 3'd1,
		CMD_ENTER_WAIT   = 3'd2,
		CMD_PROBE        = 3'd3,
		CMD_TERMINATE    = 3'd4
	} cmd_t;

	typedef enum logic [ACTION_WIDTH-1:0] {
		ACT_NONE      = 2'd0,
		ACT_PROBE     = 2'd1,
		ACT_BROADCAST = 2'd2,
		ACT_REPORT    = 2'd3
	} action_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_NODE_RANK  = 1'd0,
		REG_NODE_COUNT = 1'd1
	} reg_index_t;

	typedef struct packed {
		logic [CMD_WIDTH-1:0] command;
		logic [SUM_WIDTH-1:0] probe_sent;
		logic [SUM_WIDTH-1:0] probe_recv;
	} item_t;

	typedef struct packed {
		logic                 is_waiting;
		logic                 is_terminated;
		logic [SUM_WIDTH-1:0] probe_recv;
		logic [SUM_WIDTH-1:0] probe_sent;
		logic [RANK_WIDTH-1:0] dest_node;
		action_t              action;
	} result_t;

endpackage

// ===== design/rtd_node.sv =====
// Node state of the termination detector and the logic that handles one item.
module rtd_node #(
	parameter int COUNT_WIDTH = rtd_pkg::COUNT_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rtd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [rtd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	input  logic                                advance,
	input  rtd_pkg::item_t                      item,
	output rtd_pkg::result_t                    result
);

	logic [rtd_pkg::RANK_WIDTH-1:0]   node_rank_q;
	logic [rtd_pkg::NCOUNT_WIDTH-1:0] node_count_q;

	logic [COUNT_WIDTH-1:0] sent_count_q, recv_count_q, round_recv_q;
	logic [COUNT_WIDTH-1:0] held_sent_q, held_recv_q;
	logic first_due_q, waiting_q, done_q, held_valid_q;

	logic [COUNT_WIDTH-1:0] sent_count_d, recv_count_d, round_recv_d;
	logic [COUNT_WIDTH-1:0] held_sent_d, held_recv_d;
	logic first_due_d, waiting_d, done_d, held_valid_d;

	logic                             use_held;
	logic [COUNT_WIDTH-1:0]           pin_s, pin_r, sum_s, sum_r;
	logic [rtd_pkg::NCOUNT_WIDTH-1:0] next_rank;
	logic                             wrap;
	logic [rtd_pkg::RANK_WIDTH-1:0]   fwd_dest;
	logic                             single_node;
	logic                             do_probe;

	// A probe is processed either straight from the item or from the holding register.
	assign use_held = (item.command == rtd_pkg::CMD_ENTER_WAIT);
	assign pin_s = use_held ? held_sent_q : COUNT_WIDTH'(item.probe_sent);
	assign pin_r = use_held ? held_recv_q : COUNT_WIDTH'(item.probe_recv);
	assign sum_s = pin_s + sent_count_q;
	assign sum_r = pin_r + recv_count_q;

	// Node counts above the supported maximum are clamped to it.
	assign next_rank   = rtd_pkg::NCOUNT_WIDTH'(node_rank_q) + 1'b1;
	assign wrap        = (next_rank >= node_count_q)
		|| (32'(next_rank) >= 32'(rtd_pkg::MAX_NODES));
	assign fwd_dest    = wrap ? '0 : next_rank[rtd_pkg::RANK_WIDTH-1:0];
	assign single_node = (node_count_q < 7'd2) || (rtd_pkg::MAX_NODES < 2);

	always_comb begin
		sent_count_d = sent_count_q;
		recv_count_d = recv_count_q;
		round_recv_d = round_recv_q;
		held_sent_d  = held_sent_q;
		held_recv_d  = held_recv_q;
		first_due_d  = first_due_q;
		waiting_d    = waiting_q;
		done_d       = done_q;
		held_valid_d = held_valid_q;
		do_probe     = 1'b0;
		result.action     = rtd_pkg::ACT_NONE;
		result.dest_node  = '0;
		result.probe_sent = '0;
		result.probe_recv = '0;

		case (item.command)
			rtd_pkg::CMD_DATA_SENT: begin
				sent_count_d = sent_count_q + 1'b1;
			end
			rtd_pkg::CMD_DATA_ARRIVED: begin
				recv_count_d = recv_count_q + 1'b1;
				waiting_d    = 1'b0;
			end
			rtd_pkg::CMD_ENTER_WAIT: begin
				waiting_d = 1'b1;
				if (done_q) begin
					result.action = rtd_pkg::ACT_REPORT;
				end else if (node_rank_q == '0 && first_due_q) begin
					first_due_d = 1'b0;
					if (single_node) begin
						done_d        = 1'b1;
						result.action = rtd_pkg::ACT_REPORT;
					end else begin
						result.action    = rtd_pkg::ACT_PROBE;
						result.dest_node = rtd_pkg::RANK_WIDTH'(1);
					end
				end else if (held_valid_q) begin
					held_valid_d = 1'b0;
					do_probe     = 1'b1;
				end
			end
			rtd_pkg::CMD_PROBE: begin
				if (!done_q) begin
					if (!waiting_q) begin
						held_valid_d = 1'b1;
						held_sent_d  = COUNT_WIDTH'(item.probe_sent);
						held_recv_d  = COUNT_WIDTH'(item.probe_recv);
					end else begin
						do_probe = 1'b1;
					end
				end
			end
			rtd_pkg::CMD_TERMINATE: begin
				if (!done_q && node_rank_q != '0) begin
					done_d        = 1'b1;
					result.action = rtd_pkg::ACT_REPORT;
				end
			end
			default: begin
			end
		endcase

		if (do_probe) begin
			if (node_rank_q == '0) begin
				// The root ends the run once a full round saw no change in traffic.
				if (sum_s == round_recv_q) begin
					done_d        = 1'b1;
					result.action = rtd_pkg::ACT_BROADCAST;
				end else begin
					round_recv_d     = sum_r;
					result.action    = rtd_pkg::ACT_PROBE;
					result.dest_node = rtd_pkg::RANK_WIDTH'(1);
				end
			end else begin
				result.action     = rtd_pkg::ACT_PROBE;
				result.dest_node  = fwd_dest;
				result.probe_sent = rtd_pkg::SUM_WIDTH'(sum_s);
				result.probe_recv = rtd_pkg::SUM_WIDTH'(sum_r);
			end
		end

		result.is_terminated = done_d;
		result.is_waiting    = waiting_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_rank_q  <= '0;
			node_count_q <= rtd_pkg::NCOUNT_WIDTH'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				rtd_pkg::REG_NODE_RANK:  node_rank_q  <= cfg_data[rtd_pkg::RANK_WIDTH-1:0];
				rtd_pkg::REG_NODE_COUNT: node_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_count_q <= '0;
			recv_count_q <= '0;
			round_recv_q <= '0;
			first_due_q  <= 1'b1;
			waiting_q    <= 1'b0;
			done_q       <= 1'b0;
			held_valid_q <= 1'b0;
		end else if (advance) begin
			sent_count_q <= sent_count_d;
			recv_count_q <= recv_count_d;
			round_recv_q <= round_recv_d;
			first_due_q  <= first_due_d;
			waiting_q    <= waiting_d;
			done_q       <= done_d;
			held_valid_q <= held_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held_sent_q <= held_sent_d;
			held_recv_q <= held_recv_d;
		end
	end

endmodule

// ===== design/ring_termination_detector.sv =====
// Ring termination detector: one node of a counting-based termination ring.
//
// Events enter on the s_ channel: s_tuser carries the command (data sent, data
// arrived, enter wait, probe arrived, termination arrived) and s_tdata the
// sums of an arriving probe. Every event gives exactly one result on the m_
// channel: m_tuser holds the action, m_tdata the probe destination, the probe
// sums and the terminated and waiting flags.
// Each item passes an input register and a result register: its result is
// presented on m_ once it moves from the input register into the result
// register, and is taken at an edge where m_tready is high.
// One item per cycle is sustained while m_tready stays high; the node state is
// updated by the single add-and-compare path between the two registers.
// When m_tready is low the result register holds its item, the input
// register fills, and s_tready drops until the result is taken.
// Reset clears all counters and flags, sets rank 0 and a ring of one node,
// and arms the first probe of the root.
// The configuration port writes node_rank (index 0) or node_count (index 1);
// the user must write it only while no items are in flight: the block does not enforce this.
module ring_termination_detector #(
	parameter int COUNT_WIDTH = rtd_pkg::COUNT_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rtd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [rtd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// probe_sent_in, probe_recv_in
	input  logic [rtd_pkg::IN_DATA_WIDTH-1:0]    s_tdata,
	// command
	input  logic [rtd_pkg::CMD_WIDTH-1:0]        s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// dest_node, probe_sent_out, probe_recv_out, is_terminated, is_waiting
	output logic [rtd_pkg::OUT_DATA_WIDTH-1:0]   m_tdata,
	// action
	output logic [rtd_pkg::ACTION_WIDTH-1:0]     m_tuser
);

	rtd_pkg::item_t   item_s1;
	logic             valid_s1;
	rtd_pkg::result_t res_next;
	rtd_pkg::result_t res_q;
	logic             out_valid_q;
	logic             advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command    <= s_tuser;
			item_s1.probe_sent <= s_tdata[rtd_pkg::SUM_WIDTH-1:0];
			item_s1.probe_recv <= s_tdata[2*rtd_pkg::SUM_WIDTH-1:rtd_pkg::SUM_WIDTH];
		end
	end

	rtd_node #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_node (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.advance  (advance),
		.item     (item_s1),
		.result   (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.action;
	assign m_tdata  = {res_q.is_waiting, res_q.is_terminated, res_q.probe_recv,
		res_q.probe_sent, res_q.dest_node};

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for one node of the ring termination detector.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  RANDOM_PHASES   = 10;
	localparam int  PHASE_ITEMS     = 152;
	localparam int  AFTERMATH_ITEMS = 12;
	localparam int  MAX_IDLE        = 18;
	localparam int  MAX_REPORTS     = 10;
	localparam int  SETTLE_CYCLES   = 4;
	localparam real TIMEOUT_NS      = 2_000_000.0;

	localparam bit [rtd_pkg::CMD_WIDTH-1:0] CMD_LAST_CODE = '1;

	localparam rtd_pkg::result_t QUIET_BUSY      = '0;
	localparam rtd_pkg::result_t WRAPPED_FORWARD =
		'{is_waiting: 1'b1, action: rtd_pkg::ACT_PROBE, default: '0};

	typedef enum int {FINISH_BROADCAST, FINISH_MESSAGE, FINISH_SINGLE} finish_t;
	typedef enum int {ROW_ITEM, ROW_PINNED, ROW_REG} row_kind_t;

	// Private copy of the node state and its two registers.
	typedef struct {
		bit [rtd_pkg::RANK_WIDTH-1:0]   rank;
		bit [rtd_pkg::NCOUNT_WIDTH-1:0] count;
		bit [rtd_pkg::SUM_WIDTH-1:0]    sent;
		bit [rtd_pkg::SUM_WIDTH-1:0]    recv;
		bit [rtd_pkg::SUM_WIDTH-1:0]    round_sent;
		bit [rtd_pkg::SUM_WIDTH-1:0]    round_recv;
		bit                             first_due;
		bit                             waiting;
		bit                             done;
		bit                             held_valid;
		bit [rtd_pkg::SUM_WIDTH-1:0]    held_sent;
		bit [rtd_pkg::SUM_WIDTH-1:0]    held_recv;
	} node_t;

	typedef struct {
		row_kind_t                        kind;
		bit                               needs_first;
		bit [rtd_pkg::CMD_WIDTH-1:0]      cmd;
		bit [rtd_pkg::SUM_WIDTH-1:0]      ps;
		bit [rtd_pkg::SUM_WIDTH-1:0]      pr;
		rtd_pkg::reg_index_t              idx;
		bit [rtd_pkg::CFG_DATA_WIDTH-1:0] value;
		rtd_pkg::result_t                 res;
	} dir_row_t;

	// Rows marked needs_first rely on the root's first probe having gone out, so they
	// are left out when the run is to close on a single-node ring.
	dir_row_t directed_rows [27] = '{
		'{ROW_PINNED, 0, rtd_pkg::CMD_DATA_SENT, '0, '0, rtd_pkg::REG_NODE_RANK, 0, QUIET_BUSY},
		'{ROW_PINNED, 0, rtd_pkg::CMD_PROBE, '1, '1, rtd_pkg::REG_NODE_RANK, 0, QUIET_BUSY},
		'{ROW_PINNED, 0, rtd_pkg::CMD_TERMINATE, '0, '0, rtd_pkg::REG_NODE_RANK, 0, QUIET_BUSY},
		'{ROW_PINNED, 0, CMD_LAST_CODE, '0, '0, rtd_pkg::REG_NODE_RANK, 0, QUIET_BUSY},
		'{ROW_REG, 0, rtd_pkg::CMD_DATA_SENT, '0, '0, rtd_pkg::REG_NODE_RANK, 63, '0},
		'{ROW_REG, 0, rtd_pkg::CMD_DATA_SENT, '0, '0, rtd_pkg::REG_NODE_COUNT, 64, '0},
		'{ROW_ITEM, 0, rtd_pkg::CMD_DATA_ARRIVED, '0, '0, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_PINNED, 0, rtd_pkg::CMD_ENTER_WAIT, '0, '0, rtd_pkg::REG_NODE_RANK, 0,
			WRAPPED_FORWARD},
		'{ROW_ITEM, 0, rtd_pkg::CMD_PROBE, '0, '0, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_ITEM, 0, rtd_pkg::CMD_ENTER_WAIT, '0, '0, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_REG, 0, rtd_pkg::CMD_DATA_SENT, '0, '0, rtd_pkg::REG_NODE_RANK, 5, '0},
		'{ROW_ITEM, 0, rtd_pkg::CMD_PROBE, 32'h7FFF_FFFF, 32'h8000_0000,
			rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_REG, 0, rtd_pkg::CMD_DATA_SENT, '0, '0, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_ITEM, 0, rtd_pkg::CMD_PROBE, 32'd1, 32'd2, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_ITEM, 1, rtd_pkg::CMD_ENTER_WAIT, '0, '0, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_ITEM, 0, rtd_pkg::CMD_DATA_SENT, '0, '0, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_ITEM, 0, rtd_pkg::CMD_PROBE, 32'd0, 32'd5, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_ITEM, 0, rtd_pkg::CMD_DATA_ARRIVED, '0, '0, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_ITEM, 0, rtd_pkg::CMD_PROBE, '1, '0, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_REG, 1, rtd_pkg::CMD_DATA_SENT, '0, '0, rtd_pkg::REG_NODE_COUNT, 1, '0},
		'{ROW_ITEM, 1, rtd_pkg::CMD_ENTER_WAIT, '0, '0, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_REG, 0, rtd_pkg::CMD_DATA_SENT, '0, '0, rtd_pkg::REG_NODE_RANK, 1, '0},
		'{ROW_REG, 0, rtd_pkg::CMD_DATA_SENT, '0, '0, rtd_pkg::REG_NODE_COUNT, 2, '0},
		'{ROW_ITEM, 0, rtd_pkg::CMD_DATA_ARRIVED, '0, '0, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_ITEM, 0, rtd_pkg::CMD_ENTER_WAIT, '0, '0, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_ITEM, 0, rtd_pkg::CMD_PROBE, '1, '1, rtd_pkg::REG_NODE_RANK, 0, '0},
		'{ROW_ITEM, 0, rtd_pkg::CMD_DATA_SENT, '0, '0, rtd_pkg::REG_NODE_RANK, 0, '0}
	};

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                cfg_we    = 1'b0;
	logic [rtd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [rtd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
	logic                                s_tvalid  = 1'b0;
	logic                                s_tready;
	logic [rtd_pkg::IN_DATA_WIDTH-1:0]   s_tdata   = '0;
	logic [rtd_pkg::CMD_WIDTH-1:0]       s_tuser   = '0;
	logic                                m_tvalid;
	logic                                m_tready  = 1'b0;
	logic [rtd_pkg::OUT_DATA_WIDTH-1:0]  m_tdata;
	logic [rtd_pkg::ACTION_WIDTH-1:0]    m_tuser;

	node_t            model;
	rtd_pkg::result_t pending_results [$];
	finish_t          finish_path;
	int               failures   = 0;
	int               items_sent = 0;
	bit               send_calm  = 1'b0;
	bit               recv_calm  = 1'b0;

	ring_termination_detector dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

	function automatic int ring_size(node_t n);
		return (n.count > rtd_pkg::MAX_NODES) ? rtd_pkg::MAX_NODES : int'(n.count);
	endfunction

	function automatic void take_probe(inout node_t n, inout rtd_pkg::result_t r,
			input bit [rtd_pkg::SUM_WIDTH-1:0] ps, input bit [rtd_pkg::SUM_WIDTH-1:0] pr);
		bit [rtd_pkg::SUM_WIDTH-1:0] s_sum;
		bit [rtd_pkg::SUM_WIDTH-1:0] r_sum;
		int                          nxt;
		s_sum = ps + n.sent;
		r_sum = pr + n.recv;
		if (n.rank == 0) begin
			// The root ends the run when the sent total has caught up with the
			// received total of the previous round.
			if (s_sum == n.round_recv) begin
				n.done = 1'b1;
				r.action = rtd_pkg::ACT_BROADCAST;
			end else begin
				n.round_sent = s_sum;
				n.round_recv = r_sum;
				r.action = rtd_pkg::ACT_PROBE;
				r.dest_node = rtd_pkg::RANK_WIDTH'(1);
			end
		end else begin
			nxt = int'(n.rank) + 1;
			if (nxt >= ring_size(n))
				nxt = 0;
			r.action = rtd_pkg::ACT_PROBE;
			r.dest_node = nxt[rtd_pkg::RANK_WIDTH-1:0];
			r.probe_sent = s_sum;
			r.probe_recv = r_sum;
		end
	endfunction

	function automatic rtd_pkg::result_t node_event(inout node_t n,
			input bit [rtd_pkg::CMD_WIDTH-1:0] cmd,
			input bit [rtd_pkg::SUM_WIDTH-1:0] ps, input bit [rtd_pkg::SUM_WIDTH-1:0] pr);
		rtd_pkg::result_t r;
		r = '0;
		case (cmd)
			rtd_pkg::CMD_DATA_SENT: n.sent = n.sent + 1;
			rtd_pkg::CMD_DATA_ARRIVED: begin
				n.recv = n.recv + 1;
				n.waiting = 1'b0;
			end
			rtd_pkg::CMD_ENTER_WAIT: begin
				n.waiting = 1'b1;
				if (n.done) begin
					r.action = rtd_pkg::ACT_REPORT;
				end else if (n.rank == 0 && n.first_due) begin
					n.first_due = 1'b0;
					if (ring_size(n) < 2) begin
						n.done = 1'b1;
						r.action = rtd_pkg::ACT_REPORT;
					end else begin
						r.action = rtd_pkg::ACT_PROBE;
						r.dest_node = rtd_pkg::RANK_WIDTH'(1);
					end
				end else if (n.held_valid) begin
					n.held_valid = 1'b0;
					take_probe(n, r, n.held_sent, n.held_recv);
				end
			end
			rtd_pkg::CMD_PROBE: begin
				if (!n.done) begin
					if (!n.waiting) begin
						n.held_valid = 1'b1;
						n.held_sent = ps;
						n.held_recv = pr;
					end else begin
						take_probe(n, r, ps, pr);
					end
				end
			end
			rtd_pkg::CMD_TERMINATE: begin
				if (!n.done && n.rank != 0) begin
					n.done = 1'b1;
					r.action = rtd_pkg::ACT_REPORT;
				end
			end
			default: ;
		endcase
		r.is_terminated = n.done;
		r.is_waiting = n.waiting;
		return r;
	endfunction

	function automatic int idle_cycles(bit calm);
		return calm ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	function automatic bit [rtd_pkg::SUM_WIDTH-1:0] extreme_word();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			default: return 32'h7FFF_FFFF;
		endcase
	endfunction

	function automatic bit [rtd_pkg::CMD_WIDTH-1:0] pick_command();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 24)
			return rtd_pkg::CMD_DATA_SENT;
		else if (pick < 42)
			return rtd_pkg::CMD_DATA_ARRIVED;
		else if (pick < 62)
			return rtd_pkg::CMD_ENTER_WAIT;
		else if (pick < 90)
			return rtd_pkg::CMD_PROBE;
		else if (pick < 96)
			return rtd_pkg::CMD_TERMINATE;
		return rtd_pkg::CMD_WIDTH'($urandom_range(int'(rtd_pkg::CMD_TERMINATE) + 1,
			int'(CMD_LAST_CODE)));
	endfunction

	function automatic string describe(rtd_pkg::result_t r);
		return $sformatf("action %0d dest %0d sent %h recv %h terminated %0b waiting %0b",
			r.action, r.dest_node, r.probe_sent, r.probe_recv, r.is_terminated, r.is_waiting);
	endfunction

	// Offers one item and returns at the edge that accepts it, with valid left high.
	task automatic send_event(bit [rtd_pkg::CMD_WIDTH-1:0] cmd,
			bit [rtd_pkg::SUM_WIDTH-1:0] ps, bit [rtd_pkg::SUM_WIDTH-1:0] pr,
			bit pinned, rtd_pkg::result_t pinned_res);
		int               gap;
		rtd_pkg::result_t predicted;
		gap = idle_cycles(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {pr, ps};
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		predicted = node_event(model, cmd, ps, pr);
		pending_results.push_back(pinned ? pinned_res : predicted);
		items_sent++;
	endtask

	// Random item; anything that would end the run early is bent into a harmless one,
	// since termination cannot be undone without a second reset.
	task automatic send_random(bit [rtd_pkg::CMD_WIDTH-1:0] cmd);
		bit [rtd_pkg::SUM_WIDTH-1:0] ps;
		bit [rtd_pkg::SUM_WIDTH-1:0] pr;
		bit [rtd_pkg::SUM_WIDTH-1:0] delta;
		node_t                       trial;
		rtd_pkg::result_t            outcome;
		case ($urandom_range(0, 3))
			0: begin
				ps = $urandom;
				pr = $urandom;
			end
			1: begin
				// Near misses of the root's termination compare.
				delta = 32'd1 << $urandom_range(0, rtd_pkg::SUM_WIDTH - 1);
				if ($urandom_range(0, 1))
					delta = -delta;
				if ($urandom_range(0, 3) == 0)
					delta = '0;
				ps = model.round_recv - model.sent + delta;
				pr = $urandom_range(0, 255);
			end
			2: begin
				ps = $urandom_range(0, 1000);
				pr = $urandom_range(0, 1000);
			end
			default: begin
				ps = extreme_word();
				pr = extreme_word();
			end
		endcase
		if (finish_path == FINISH_SINGLE && cmd == rtd_pkg::CMD_ENTER_WAIT && model.rank == 0
				&& model.first_due)
			cmd = rtd_pkg::CMD_DATA_SENT;
		trial = model;
		outcome = node_event(trial, cmd, ps, pr);
		if (trial.done && !model.done) begin
			if (cmd == rtd_pkg::CMD_PROBE)
				ps = ps ^ 32'd1;
			else
				cmd = rtd_pkg::CMD_DATA_SENT;
		end
		send_event(cmd, ps, pr, 1'b0, '0);
	endtask

	// Mostly a node's working life: some traffic, going idle, then probes.
	task automatic random_round();
		if ($urandom_range(0, 3) != 0) begin
			repeat ($urandom_range(0, 4))
				send_random($urandom_range(0, 1) ? rtd_pkg::CMD_DATA_SENT
					: rtd_pkg::CMD_DATA_ARRIVED);
			send_random(rtd_pkg::CMD_ENTER_WAIT);
			repeat ($urandom_range(1, 2))
				send_random(rtd_pkg::CMD_PROBE);
		end else begin
			repeat ($urandom_range(1, 6))
				send_random(pick_command());
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(rtd_pkg::reg_index_t idx,
			bit [rtd_pkg::CFG_DATA_WIDTH-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == rtd_pkg::REG_NODE_RANK)
			model.rank = value[rtd_pkg::RANK_WIDTH-1:0];
		else
			model.count = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(bit [rtd_pkg::RANK_WIDTH-1:0] rk,
			bit [rtd_pkg::NCOUNT_WIDTH-1:0] cnt);
		write_reg(rtd_pkg::REG_NODE_RANK, {1'b0, rk});
		write_reg(rtd_pkg::REG_NODE_COUNT, cnt);
	endtask

	task automatic check_result(rtd_pkg::result_t got);
		rtd_pkg::result_t want;
		if (pending_results.size() == 0) begin
			failures++;
			if (failures <= MAX_REPORTS)
				$display("%0t: result with nothing expected: %s", $realtime, describe(got));
			return;
		end
		want = pending_results.pop_front();
		if (got.action !== want.action || got.dest_node !== want.dest_node
				|| got.probe_sent !== want.probe_sent || got.probe_recv !== want.probe_recv
				|| got.is_terminated !== want.is_terminated
				|| got.is_waiting !== want.is_waiting) begin
			failures++;
			if (failures <= MAX_REPORTS) begin
				$display("%0t: result mismatch", $realtime);
				$display("  expected %s", describe(want));
				$display("  actual   %s", describe(got));
			end
		end
	endtask

	initial begin
		rtd_pkg::result_t got;
		int               stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_cycles(recv_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(negedge clk);
			while (!m_tvalid) @(negedge clk);
			got = rtd_pkg::result_t'({m_tdata, m_tuser});
			@(posedge clk);
			check_result(got);
		end
	end

	initial begin
		bit [rtd_pkg::RANK_WIDTH-1:0]   rk;
		bit [rtd_pkg::NCOUNT_WIDTH-1:0] cnt;
		int                             target;
		model = '{count: 1, first_due: 1'b1, default: '0};
		finish_path = finish_t'($urandom_range(0, 2));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].needs_first && finish_path == FINISH_SINGLE)
				continue;
			if (directed_rows[i].kind == ROW_REG) begin
				settle();
				write_reg(directed_rows[i].idx, directed_rows[i].value);
			end else begin
				send_event(directed_rows[i].cmd, directed_rows[i].ps, directed_rows[i].pr,
					directed_rows[i].kind == ROW_PINNED, directed_rows[i].res);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			send_calm = (ph % 4 == 0) || (ph % 4 == 3);
			recv_calm = (ph % 4 == 0) || (ph % 4 == 2);
			case (ph % 4)
				0: rk = '0;
				1: rk = '1;
				default: rk = rtd_pkg::RANK_WIDTH'($urandom_range(0,
					(1 << rtd_pkg::RANK_WIDTH) - 1));
			endcase
			case (ph % 3)
				0: cnt = rtd_pkg::NCOUNT_WIDTH'(rtd_pkg::MAX_NODES);
				1: cnt = rtd_pkg::NCOUNT_WIDTH'(1);
				default: cnt = rtd_pkg::NCOUNT_WIDTH'($urandom_range(1, rtd_pkg::MAX_NODES));
			endcase
			configure(rk, cnt);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) random_round();
		end

		// Closing phase: drive the node into termination by one of its routes and
		// check how it behaves afterwards.
		settle();
		send_calm = 1'b0;
		recv_calm = 1'b0;
		if (finish_path == FINISH_SINGLE && !model.first_due)
			finish_path = FINISH_BROADCAST;
		case (finish_path)
			FINISH_SINGLE: begin
				configure('0, rtd_pkg::NCOUNT_WIDTH'(1));
				send_event(rtd_pkg::CMD_ENTER_WAIT, '0, '0, 1'b0, '0);
			end
			FINISH_MESSAGE: begin
				configure(rtd_pkg::RANK_WIDTH'($urandom_range(1, (1 << rtd_pkg::RANK_WIDTH) - 1)),
					rtd_pkg::NCOUNT_WIDTH'($urandom_range(2, rtd_pkg::MAX_NODES)));
				send_event(rtd_pkg::CMD_TERMINATE, $urandom, $urandom, 1'b0, '0);
			end
			default: begin
				configure('0, rtd_pkg::NCOUNT_WIDTH'($urandom_range(2, rtd_pkg::MAX_NODES)));
				send_event(rtd_pkg::CMD_ENTER_WAIT, '0, '0, 1'b0, '0);
				send_event(rtd_pkg::CMD_PROBE, model.round_recv - model.sent, $urandom, 1'b0,
					'0);
			end
		endcase
		repeat (AFTERMATH_ITEMS) send_random(pick_command());
		settle();

		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
